[rtl/dpi_pkg.sv]
// shared types, constants and arithmetic helpers of the particle integrator
package dpi_pkg;

	localparam int unsigned DIV_W = 64;
	localparam int unsigned QUO_W = 40;

	localparam logic [16:0] K_AIR    = 17'd64881;
	localparam logic [16:0] K_HITACC = 17'd58982;
	localparam logic [16:0] K_BOUNCE = 17'd91750;
	localparam logic [24:0] REST_LIMIT = 25'd4294968;

	localparam logic [1:0] KIND_TICK    = 2'd0;
	localparam logic [1:0] KIND_FORCE   = 2'd1;
	localparam logic [1:0] KIND_GRAVITY = 2'd2;
	localparam logic [1:0] KIND_HIT     = 2'd3;

	localparam logic [1:0] REG_MASS    = 2'd0;
	localparam logic [1:0] REG_START_X = 2'd1;
	localparam logic [1:0] REG_START_Y = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic [15:0]        step_time;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic               at_rest;
	} rsp_t;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6, ST_T7, ST_T8,
		ST_F0, ST_F1, ST_F2, ST_F3,
		ST_G,
		ST_H0, ST_H1, ST_H2, ST_HN,
		ST_HM0, ST_HM1, ST_HM2, ST_HD1, ST_HD2,
		ST_RX0, ST_RX1, ST_RX2, ST_RX3,
		ST_RY0, ST_RY1, ST_RY2, ST_RY3,
		ST_HB0, ST_HB1, ST_HB2,
		ST_DONE
	} state_t;

	function automatic logic [31:0] abs32(input logic signed [31:0] x);
		return x[31] ? 32'(-x) : 32'(x);
	endfunction

	function automatic logic signed [63:0] sx64(input logic signed [31:0] x);
		return {{32{x[31]}}, x};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	// magnitude rounded to nearest, ties away from zero, then signed
	function automatic logic signed [63:0] rnd_shift(input logic [49:0] mag, input logic neg,
		input int unsigned sh);
		logic [50:0] t;
		logic [63:0] m;
		t = {1'b0, mag} + (51'd1 << (sh - 1));
		m = 64'(t >> sh);
		return neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic rest_ok(input logic signed [31:0] x, input logic signed [31:0] y);
		logic [31:0] mx;
		logic [31:0] my;
		logic [23:0] qx;
		logic [23:0] qy;
		logic [24:0] s;
		mx = abs32(x);
		my = abs32(y);
		qx = mx[11:0] * mx[11:0];
		qy = my[11:0] * my[11:0];
		s = {1'b0, qx} + {1'b0, qy};
		if (mx >= 32'd4096 || my >= 32'd4096) return 1'b0;
		return s < REST_LIMIT;
	endfunction

endpackage

[rtl/dpi_mul.sv]
// shared magnitude multiplier with registered product and sign
module dpi_mul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic [16:0]        b,
	input  logic               b_neg,
	output logic [49:0]        prod_s1,
	output logic               neg_s1
);
	import dpi_pkg::*;

	logic [32:0] a_mag;

	assign a_mag = a[32] ? 33'(-a) : 33'(a);

	always_ff @(posedge clk) begin
		prod_s1 <= 50'(a_mag) * 50'(b);
		neg_s1  <= a[32] ^ b_neg;
	end
endmodule

[rtl/dpi_div.sv]
// restoring unsigned divider, one quotient bit per cycle
module dpi_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [dpi_pkg::DIV_W-1:0] dividend,
	input  logic [31:0]              divisor,
	output logic                     done,
	output logic [dpi_pkg::QUO_W-1:0] quotient
);
	import dpi_pkg::*;

	logic [DIV_W-1:0] dq_q;
	logic [31:0]      rem_q;
	logic [31:0]      dvs_q;
	logic [6:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [32:0]      r2;
	logic             qbit;

	assign r2   = {rem_q, dq_q[DIV_W-1]};
	assign qbit = r2 >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? 32'(r2 - {1'b0, dvs_q}) : r2[31:0];
			dq_q  <= {dq_q[DIV_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q[QUO_W-1:0];
endmodule

[rtl/damped_particle_integrator.sv]
// damped 2d point-mass integrator, top level with sequencer and apb registers
// One item at a time through a small sequencer around one shared 33x17 multiplier and
// a 64-step restoring divider. A force takes two divisions at one quotient bit per cycle,
// a hit with a zero normal skips the reflection, and any other hit takes two divisions
// plus a normalization of the surface normal. The result is then held in an output
// register so the next item can be taken while it waits.
module damped_particle_integrator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  dpi_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dpi_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import dpi_pkg::*;

	state_t state_q, state_d;

	logic [15:0]        mass_q;
	logic signed [31:0] sx_q, sy_q;
	logic signed [31:0] ax_q, ay_q, vx_q, vy_q, dx_q, dy_q;
	logic signed [31:0] wx_q, wy_q;
	logic [15:0]        dt_q;
	logic [31:0]        nx_q, ny_q;
	logic               nsx_q, nsy_q;
	logic               rest_q;
	logic [31:0]        mm_q;
	logic signed [48:0] d_q;
	logic [46:0]        acc_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic signed [32:0] mul_a;
	logic [16:0]        mul_b;
	logic               mul_bneg;
	logic [49:0]        mul_p_s1;
	logic               mul_neg_s1;

	logic               div_start;
	logic [DIV_W-1:0]   div_dvd;
	logic [31:0]        div_dvs;
	logic               div_done;
	logic [QUO_W-1:0]   div_q;

	logic               accept;
	logic               cfg_wr;
	logic signed [63:0] rs16, rs17;
	logic [47:0]        dmag;
	logic signed [48:0] pd;
	logic [63:0]        num;
	logic signed [63:0] qpos;
	logic [31:0]        big;
	logic [15:0]        mass_eff;

	dpi_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.b_neg  (mul_bneg),
		.prod_s1(mul_p_s1),
		.neg_s1 (mul_neg_s1)
	);

	dpi_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.done    (div_done),
		.quotient(div_q)
	);

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;

	assign rs16     = rnd_shift(mul_p_s1, mul_neg_s1, 16);
	assign rs17     = rnd_shift(mul_p_s1, mul_neg_s1, 17);
	assign dmag     = d_q[48] ? 48'(-d_q) : 48'(d_q);
	assign pd       = {1'b0, mul_p_s1[47:0]};
	assign num      = (64'(acc_q) + {mul_p_s1[31:0], 32'd0}) << 1;
	assign qpos     = $signed(64'(div_q));
	assign big      = (nx_q > ny_q) ? nx_q : ny_q;
	assign mass_eff = (mass_q == 16'd0) ? 16'd1 : mass_q;

	always_comb begin
		unique case (paddr[3:2])
			REG_MASS:    prdata = {16'd0, mass_q};
			REG_START_X: prdata = sx_q;
			REG_START_Y: prdata = sy_q;
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= 16'd256;
			sx_q   <= '0;
			sy_q   <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MASS:    mass_q <= pwdata[15:0];
				REG_START_X: sx_q   <= pwdata;
				REG_START_Y: sy_q   <= pwdata;
				default:     ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd.kind)
						KIND_TICK:    state_d = ST_T0;
						KIND_FORCE:   state_d = ST_F0;
						KIND_GRAVITY: state_d = ST_G;
						KIND_HIT:     state_d = ST_H0;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_T0:  state_d = ST_T1;
			ST_T1:  state_d = ST_T2;
			ST_T2:  state_d = ST_T3;
			ST_T3:  state_d = ST_T4;
			ST_T4:  state_d = ST_T5;
			ST_T5:  state_d = ST_T6;
			ST_T6:  state_d = ST_T7;
			ST_T7:  state_d = ST_T8;
			ST_T8:  state_d = ST_DONE;
			ST_F0:  state_d = ST_F1;
			ST_F1:  if (div_done) state_d = ST_F2;
			ST_F2:  state_d = ST_F3;
			ST_F3:  if (div_done) state_d = ST_DONE;
			ST_G:   state_d = ST_DONE;
			ST_H0:  state_d = ST_H1;
			ST_H1:  state_d = ST_H2;
			ST_H2:  state_d = (nx_q == '0 && ny_q == '0) ? ST_HB0 : ST_HN;
			ST_HN:  if (big < 32'd32768 && big >= 32'd16384) state_d = ST_HM0;
			ST_HM0: state_d = ST_HM1;
			ST_HM1: state_d = ST_HM2;
			ST_HM2: state_d = ST_HD1;
			ST_HD1: state_d = ST_HD2;
			ST_HD2: state_d = ST_RX0;
			ST_RX0: state_d = ST_RX1;
			ST_RX1: state_d = ST_RX2;
			ST_RX2: state_d = ST_RX3;
			ST_RX3: if (div_done) state_d = ST_RY0;
			ST_RY0: state_d = ST_RY1;
			ST_RY1: state_d = ST_RY2;
			ST_RY2: state_d = ST_RY3;
			ST_RY3: if (div_done) state_d = ST_HB0;
			ST_HB0: state_d = ST_HB1;
			ST_HB1: state_d = ST_HB2;
			ST_HB2: state_d = ST_DONE;
			ST_DONE: if (!rsp_valid_q || !rsp_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// shared unit operands
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		mul_bneg  = 1'b0;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		unique case (state_q)
			ST_T0: begin mul_a = {ax_q[31], ax_q}; mul_b = K_AIR; end
			ST_T1: begin mul_a = {ay_q[31], ay_q}; mul_b = K_AIR; end
			ST_T2: begin mul_a = {vx_q[31], vx_q}; mul_b = K_AIR; end
			ST_T3: begin mul_a = {vy_q[31], vy_q}; mul_b = K_AIR; end
			ST_T5: begin
				mul_a = {wx_q[31], wx_q} + {vx_q[31], vx_q};
				mul_b = {1'b0, dt_q};
			end
			ST_T6: begin
				mul_a = {wy_q[31], wy_q} + {vy_q[31], vy_q};
				mul_b = {1'b0, dt_q};
			end
			ST_F0: begin
				div_start = 1'b1;
				div_dvd   = {24'd0, nx_q, 8'd0};
				div_dvs   = {16'd0, mass_eff};
			end
			ST_F2: begin
				div_start = 1'b1;
				div_dvd   = {24'd0, ny_q, 8'd0};
				div_dvs   = {16'd0, mass_eff};
			end
			ST_H0:  begin mul_a = {ax_q[31], ax_q}; mul_b = K_HITACC; end
			ST_H1:  begin mul_a = {ay_q[31], ay_q}; mul_b = K_HITACC; end
			ST_HM0: begin mul_a = {1'b0, nx_q}; mul_b = nx_q[16:0]; end
			ST_HM1: begin mul_a = {1'b0, ny_q}; mul_b = ny_q[16:0]; end
			ST_HM2: begin mul_a = {vx_q[31], vx_q}; mul_b = nx_q[16:0]; mul_bneg = nsx_q; end
			ST_HD1: begin mul_a = {vy_q[31], vy_q}; mul_b = ny_q[16:0]; mul_bneg = nsy_q; end
			ST_RX0: begin mul_a = {1'b0, dmag[31:0]}; mul_b = nx_q[16:0]; end
			ST_RX1: begin mul_a = {17'd0, dmag[47:32]}; mul_b = nx_q[16:0]; end
			ST_RX2: begin
				div_start = 1'b1;
				div_dvd   = num + 64'(mm_q >> 1);
				div_dvs   = mm_q;
			end
			ST_RY0: begin mul_a = {1'b0, dmag[31:0]}; mul_b = ny_q[16:0]; end
			ST_RY1: begin mul_a = {17'd0, dmag[47:32]}; mul_b = ny_q[16:0]; end
			ST_RY2: begin
				div_start = 1'b1;
				div_dvd   = num + 64'(mm_q >> 1);
				div_dvs   = mm_q;
			end
			ST_HB0: begin mul_a = {vx_q[31], vx_q}; mul_b = K_BOUNCE; end
			ST_HB1: begin mul_a = {vy_q[31], vy_q}; mul_b = K_BOUNCE; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			ax_q        <= '0;
			ay_q        <= '0;
			vx_q        <= '0;
			vy_q        <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
		end else begin
			state_q <= state_d;
			if (rsp_valid_q && !rsp_stall && state_q != ST_DONE) rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_T1: ax_q <= sat32(rs16);
				ST_T2: ay_q <= sat32(rs16);
				ST_T4: vx_q <= sat32(sx64(wx_q) + sx64(ax_q));
				ST_T5: vy_q <= sat32(sx64(wy_q) + sx64(ay_q));
				ST_T6: dx_q <= sat32(sx64(dx_q) + rs17);
				ST_T7: dy_q <= sat32(sx64(dy_q) + rs17);
				ST_T8: begin
					if (rest_ok(ax_q, ay_q) && rest_ok(vx_q, vy_q)) begin
						ax_q <= '0;
						ay_q <= '0;
						vx_q <= '0;
						vy_q <= '0;
					end
				end
				ST_F1: if (div_done) ax_q <= sat32(sx64(ax_q) + (nsx_q ? -qpos : qpos));
				ST_F3: if (div_done) ay_q <= sat32(sx64(ay_q) + (nsy_q ? -qpos : qpos));
				ST_G: begin
					ax_q <= sat32(sx64(ax_q) + sx64(wx_q));
					ay_q <= sat32(sx64(ay_q) + sx64(wy_q));
				end
				ST_H1: ax_q <= sat32(rs16);
				ST_H2: ay_q <= sat32(rs16);
				ST_RX3: begin
					if (div_done) vx_q <= sat32(sx64(vx_q) - ((nsx_q ^ d_q[48]) ? -qpos : qpos));
				end
				ST_RY3: begin
					if (div_done) vy_q <= sat32(sx64(vy_q) - ((nsy_q ^ d_q[48]) ? -qpos : qpos));
				end
				ST_HB1: vx_q <= sat32(rs16);
				ST_HB2: vy_q <= sat32(rs16);
				ST_DONE: if (!rsp_valid_q || !rsp_stall) rsp_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					wx_q   <= cmd.vec_x;
					wy_q   <= cmd.vec_y;
					dt_q   <= cmd.step_time;
					nx_q   <= abs32(cmd.vec_x);
					ny_q   <= abs32(cmd.vec_y);
					nsx_q  <= cmd.vec_x[31];
					nsy_q  <= cmd.vec_y[31];
					rest_q <= 1'b0;
				end
			end
			ST_T3: wx_q <= sat32(rs16);
			ST_T4: wy_q <= sat32(rs16);
			ST_T8: rest_q <= rest_ok(ax_q, ay_q) && rest_ok(vx_q, vy_q);
			ST_HN: begin
				if (big >= 32'd32768) begin
					nx_q <= nx_q >> 1;
					ny_q <= ny_q >> 1;
				end else if (big < 32'd16384) begin
					nx_q <= nx_q << 1;
					ny_q <= ny_q << 1;
				end
			end
			ST_HM1: mm_q <= mul_p_s1[31:0];
			ST_HM2: mm_q <= mm_q + mul_p_s1[31:0];
			ST_HD1: d_q <= mul_neg_s1 ? -pd : pd;
			ST_HD2: d_q <= d_q + (mul_neg_s1 ? -pd : pd);
			ST_RX1: acc_q <= mul_p_s1[46:0];
			ST_RY1: acc_q <= mul_p_s1[46:0];
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_q.pos_x   <= sat32(sx64(sx_q) + sx64(dx_q));
					rsp_q.pos_y   <= sat32(sx64(sy_q) + sx64(dy_q));
					rsp_q.vel_x   <= vx_q;
					rsp_q.vel_y   <= vy_q;
					rsp_q.at_rest <= rest_q;
				end
			end
			default: ;
		endcase
	end
endmodule

[tb/damped_particle_integrator_test.sv]
// self-checking testbench for the damped particle integrator: directed and random items
`timescale 1ns / 1ps

module damped_particle_integrator_test;
	import dpi_pkg::*;

	localparam longint CYCLE_LIMIT = 64'd2000000;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	cmd_t        cmd;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	damped_particle_integrator dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// model state
	logic [15:0]        m_mass;
	logic signed [31:0] m_start_x, m_start_y;
	logic signed [31:0] m_ax, m_ay, m_vx, m_vy, m_dx, m_dy;

	rsp_t   expected_rsp[$];
	int     errors;
	longint cycles;
	int     hold_cycles;
	bit     rsp_random_stall;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic signed [31:0] clamp32(input longint x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	function automatic longint round_shift(input longint x, input int s);
		longint h;
		h = longint'(1) << (s - 1);
		if (x >= 0) return (x + h) >>> s;
		return -((-x + h) >>> s);
	endfunction

	function automatic logic signed [31:0] qscale(input logic signed [31:0] x, input longint k);
		return clamp32(round_shift(longint'(x) * k, 16));
	endfunction

	function automatic longint unsigned magn(input longint x);
		return x < 0 ? longint'(-x) : x;
	endfunction

	function automatic bit below_rest(input logic signed [31:0] x, input logic signed [31:0] y);
		longint unsigned a, b;
		a = magn(x);
		b = magn(y);
		return (a * a + b * b) < 64'd4294968;
	endfunction

	function automatic logic signed [31:0] mirror(input logic signed [31:0] v, input longint m,
		input longint d, input longint unsigned mm);
		longint unsigned num, md;
		longint q;
		md = magn(d);
		num = 2 * magn(m) * md;
		q = longint'((num + mm / 2) / mm);
		if ((m < 0) != (d < 0)) q = -q;
		return clamp32(longint'(v) - q);
	endfunction

	function automatic rsp_t predict_motion(input cmd_t c);
		rsp_t r;
		logic signed [31:0] wx, wy;
		longint unsigned nx, ny, big, mm;
		longint mx, my, d, dv;
		r.at_rest = 1'b0;
		case (c.kind)
			KIND_TICK: begin
				m_ax = qscale(m_ax, K_AIR);
				m_ay = qscale(m_ay, K_AIR);
				m_vx = qscale(m_vx, K_AIR);
				m_vy = qscale(m_vy, K_AIR);
				wx = m_vx;
				wy = m_vy;
				m_vx = clamp32(longint'(m_vx) + m_ax);
				m_vy = clamp32(longint'(m_vy) + m_ay);
				m_dx = clamp32(longint'(m_dx)
					+ round_shift((longint'(wx) + m_vx) * longint'(c.step_time), 17));
				m_dy = clamp32(longint'(m_dy)
					+ round_shift((longint'(wy) + m_vy) * longint'(c.step_time), 17));
				if (below_rest(m_ax, m_ay) && below_rest(m_vx, m_vy)) begin
					m_ax = 0;
					m_ay = 0;
					m_vx = 0;
					m_vy = 0;
					r.at_rest = 1'b1;
				end
			end
			KIND_FORCE: begin
				dv = m_mass == 0 ? 1 : longint'(m_mass);
				m_ax = clamp32(longint'(m_ax) + (longint'(c.vec_x) * 256) / dv);
				m_ay = clamp32(longint'(m_ay) + (longint'(c.vec_y) * 256) / dv);
			end
			KIND_GRAVITY: begin
				m_ax = clamp32(longint'(m_ax) + c.vec_x);
				m_ay = clamp32(longint'(m_ay) + c.vec_y);
			end
			default: begin
				m_ax = qscale(m_ax, K_HITACC);
				m_ay = qscale(m_ay, K_HITACC);
				nx = magn(c.vec_x);
				ny = magn(c.vec_y);
				if (nx != 0 || ny != 0) begin
					big = nx > ny ? nx : ny;
					while (big >= 32768) begin
						nx >>= 1;
						ny >>= 1;
						big >>= 1;
					end
					while (big < 16384) begin
						nx <<= 1;
						ny <<= 1;
						big <<= 1;
					end
					mx = c.vec_x < 0 ? -longint'(nx) : longint'(nx);
					my = c.vec_y < 0 ? -longint'(ny) : longint'(ny);
					mm = nx * nx + ny * ny;
					d = longint'(m_vx) * mx + longint'(m_vy) * my;
					m_vx = mirror(m_vx, mx, d, mm);
					m_vy = mirror(m_vy, my, d, mm);
				end
				m_vx = qscale(m_vx, K_BOUNCE);
				m_vy = qscale(m_vy, K_BOUNCE);
			end
		endcase
		r.pos_x = clamp32(longint'(m_start_x) + m_dx);
		r.pos_y = clamp32(longint'(m_start_y) + m_dy);
		r.vel_x = m_vx;
		r.vel_y = m_vy;
		return r;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
	endfunction

	task automatic wait_cycles(input int n);
		repeat (n) @(posedge clk);
	endtask

	task automatic send_item(input cmd_t c, input bit gaps);
		int n;
		n = gaps ? gap_len() : 0;
		if (n > 0) begin
			cmd_valid <= 1'b0;
			wait_cycles(n);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		expected_rsp.push_back(predict_motion(c));
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		wait_cycles(200);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MASS:    m_mass = value[15:0];
			REG_START_X: m_start_x = value;
			REG_START_Y: m_start_y = value;
			default: ;
		endcase
	endtask

	function automatic cmd_t make_cmd(input logic [1:0] k, input logic [31:0] x,
		input logic [31:0] y, input logic [15:0] t);
		cmd_t c;
		c.kind = k;
		c.vec_x = x;
		c.vec_y = y;
		c.step_time = t;
		return c;
	endfunction

	function automatic logic [31:0] rand_vec();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 131072)) - 65536);
			2: return 32'($signed($urandom_range(0, 2000)) - 1000);
			3: return 32'($signed($urandom_range(0, 16777216)) - 8388608);
			default: return 0;
		endcase
	endfunction

	function automatic cmd_t rand_cmd();
		logic [1:0] k;
		k = 2'($urandom_range(0, 3));
		return make_cmd(k, rand_vec(), rand_vec(), 16'($urandom()));
	endfunction

	task automatic test_directed();
		send_item(make_cmd(KIND_TICK, 32'h12345678, 32'h87654321, 16'hffff), 1'b0);
		send_item(make_cmd(KIND_GRAVITY, 32'h7fffffff, 32'h80000000, 16'd0), 1'b0);
		send_item(make_cmd(KIND_GRAVITY, 32'h7fffffff, 32'h80000000, 16'd0), 1'b0);
		send_item(make_cmd(KIND_TICK, 0, 0, 16'hffff), 1'b0);
		send_item(make_cmd(KIND_HIT, 0, 0, 16'hffff), 1'b0);
		send_item(make_cmd(KIND_HIT, 32'h00010000, 0, 16'd0), 1'b0);
		send_item(make_cmd(KIND_HIT, 32'h80000000, 32'h7fffffff, 16'd0), 1'b0);
		send_item(make_cmd(KIND_HIT, 1, 32'hffffffff, 16'd0), 1'b0);
		send_item(make_cmd(KIND_FORCE, 32'h80000000, 32'h7fffffff, 16'd0), 1'b0);
		send_item(make_cmd(KIND_TICK, 0, 0, 16'd0), 1'b0);
		send_item(make_cmd(KIND_FORCE, 32'hfffe0000, 32'h00030000, 16'h1234), 1'b0);
		send_item(make_cmd(KIND_TICK, 0, 0, 16'h8000), 1'b0);
		drain();
		write_reg(REG_MASS, 32'd0);
		write_reg(REG_START_X, 32'h7fffffff);
		write_reg(REG_START_Y, 32'h80000000);
		send_item(make_cmd(KIND_FORCE, 32'h00000100, 32'hffffff00, 16'd0), 1'b0);
		send_item(make_cmd(KIND_TICK, 0, 0, 16'hffff), 1'b0);
		send_item(make_cmd(KIND_FORCE, 32'h7fffffff, 32'h80000000, 16'd0), 1'b0);
		drain();
		write_reg(REG_MASS, 32'h0000ffff);
		write_reg(REG_START_X, 32'h80000000);
		write_reg(REG_START_Y, 32'h7fffffff);
		send_item(make_cmd(KIND_FORCE, 32'h7fffffff, 32'h80000000, 16'd0), 1'b0);
		send_item(make_cmd(KIND_TICK, 0, 0, 16'hffff), 1'b0);
		for (int i = 0; i < 5; i++) send_item(make_cmd(KIND_TICK, 0, 0, 16'h0100), 1'b0);
		drain();
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 4; p++) begin
			write_reg(REG_MASS, 32'($urandom_range(1, 1024)));
			write_reg(REG_START_X, rand_vec());
			write_reg(REG_START_Y, rand_vec());
			for (int i = 0; i < 190; i++) send_item(rand_cmd(), 1'b1);
			drain();
		end
	endtask

	task automatic test_backpressure();
		rsp_random_stall = 0;
		hold_cycles = 3000;
		for (int i = 0; i < 40; i++) send_item(rand_cmd(), 1'b0);
		drain();
		rsp_random_stall = 1;
		for (int i = 0; i < 30; i++) send_item(rand_cmd(), 1'b0);
		drain();
		write_reg(REG_MASS, 32'd256);
		write_reg(REG_START_X, 0);
		write_reg(REG_START_Y, 0);
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp_stall <= 1'b1;
		end else if (rsp_random_stall) begin
			rsp_stall <= ($urandom_range(0, 3) == 0);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = expected_rsp.pop_front();
				if (rsp.pos_x !== e.pos_x) begin
					$error("pos_x expected %h actual %h", e.pos_x, rsp.pos_x);
					errors++;
				end
				if (rsp.pos_y !== e.pos_y) begin
					$error("pos_y expected %h actual %h", e.pos_y, rsp.pos_y);
					errors++;
				end
				if (rsp.vel_x !== e.vel_x) begin
					$error("vel_x expected %h actual %h", e.vel_x, rsp.vel_x);
					errors++;
				end
				if (rsp.vel_y !== e.vel_y) begin
					$error("vel_y expected %h actual %h", e.vel_y, rsp.vel_y);
					errors++;
				end
				if (rsp.at_rest !== e.at_rest) begin
					$error("at_rest expected %b actual %b", e.at_rest, rsp.at_rest);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		rsp_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		cycles = 0;
		hold_cycles = 0;
		rsp_random_stall = 1;
		m_mass = 16'd256;
		m_start_x = 0;
		m_start_y = 0;
		m_ax = 0;
		m_ay = 0;
		m_vx = 0;
		m_vy = 0;
		m_dx = 0;
		m_dy = 0;
		wait_cycles(6);
		arst_n <= 1'b1;
		wait_cycles(2);
		test_directed();
		test_random_phases();
		test_backpressure();
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
